// ===== design/bmeu_pkg.sv =====
// Package for the byte machine execute unit: operation codes, sizes and the
// 8-bit float adder used in the execute stage.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package bmeu_pkg;

   localparam int unsigned REG_COUNT   = 16;
   localparam int unsigned REG_AW      = 4;
   localparam int unsigned MEM_DEPTH   = 256;
   localparam int unsigned BYTE_VALUES = 256;

   localparam logic [3:0] OP_LDMEM = 4'd0;
   localparam logic [3:0] OP_LDIMM = 4'd1;
   localparam logic [3:0] OP_STORE = 4'd2;
   localparam logic [3:0] OP_MOVE  = 4'd3;
   localparam logic [3:0] OP_ADD   = 4'd4;
   localparam logic [3:0] OP_FADD  = 4'd5;
   localparam logic [3:0] OP_OR    = 4'd6;
   localparam logic [3:0] OP_AND   = 4'd7;
   localparam logic [3:0] OP_XOR   = 4'd8;
   localparam logic [3:0] OP_ROR   = 4'd9;
   localparam logic [3:0] OP_JEQ   = 4'd10;
   localparam logic [3:0] OP_HALT  = 4'd11;
   localparam logic [3:0] OP_JGT   = 4'd12;

   typedef logic [7:0] byte_type;

   // Adds two 8-bit floats (sign, excess-4 exponent, four mantissa bits with a
   // hidden one). The exact sum is truncated towards zero, tiny sums flush to
   // zero and large ones saturate at the largest magnitude of their sign.
   function automatic byte_type float_add(input byte_type a, input byte_type b);
      logic [11:0] mag_a;
      logic [11:0] mag_b;
      logic [12:0] mag;
      logic        neg;
      logic [3:0]  lead;
      logic [3:0]  shift;
      logic [12:0] norm;
      byte_type    res;
      mag_a = 12'({1'b1, a[3:0]}) << a[6:4];
      mag_b = 12'({1'b1, b[3:0]}) << b[6:4];
      if (a[7] == b[7]) begin
         mag = {1'b0, mag_a} + {1'b0, mag_b};
         neg = a[7];
      end else if (mag_a >= mag_b) begin
         mag = {1'b0, mag_a - mag_b};
         neg = a[7];
      end else begin
         mag = {1'b0, mag_b - mag_a};
         neg = b[7];
      end
      lead = 4'd0;
      for (int i = 0; i < 13; i++) begin
         if (mag[i]) begin
            lead = 4'(i);
         end
      end
      shift = lead - 4'd4;
      norm  = mag >> shift;
      if (mag == 13'd0 || lead < 4'd4) begin
         res = 8'h00;
      end else if (lead > 4'd11) begin
         res = {neg, 7'h7F};
      end else begin
         res = {neg, shift[2:0], norm[3:0]};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/byte_machine_execute_unit.sv =====
// Top level of the byte machine execute unit: register file, data memory,
// execute stage and result register. Depends on bmeu_pkg.
// An accepted request is registered into the execute stage, and its result is
// registered into the result register, which drives the outputs, when it leaves.
// One request per cycle unless the output stalls; the register file and the data
// memory are each read at the accept edge and written when the request leaves
// the execute stage, and a write at the same edge as the next read is forwarded.
// Reset clears the control state and the valid bits of both stores at once, so
// no clearing pass is needed and requests are taken as soon as reset is released.
`default_nettype none

module byte_machine_execute_unit #(
   parameter int unsigned MEM_DEPTH = bmeu_pkg::MEM_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [3:0] req_operation,
   input  wire logic [3:0] req_reg_r,
   input  wire logic [3:0] req_reg_s,
   input  wire logic [3:0] req_reg_t,
   input  wire logic [7:0] req_address_byte,
   input  wire logic [7:0] req_current_pc,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_next_pc,
   output logic            rsp_jump_taken,
   output logic            rsp_halted,
   output logic [7:0]      rsp_written_value
);

   localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);
   localparam int unsigned REG_AW = bmeu_pkg::REG_AW;

   // Address wrap table: the byte address taken modulo the memory depth,
   // worked out while the design is elaborated.
   logic [MEM_AW-1:0] wrap_tab [bmeu_pkg::BYTE_VALUES];
   for (genvar g = 0; g < bmeu_pkg::BYTE_VALUES; g++) begin : g_wrap
      localparam int unsigned WRAPPED = g % MEM_DEPTH;
      assign wrap_tab[g] = MEM_AW'(WRAPPED);
   end

   // Storage. The register file has two read ports and one write port; the
   // data memory one of each. Each entry carries a valid bit which reset
   // clears, and an entry that was never written reads as zero.
   bmeu_pkg::byte_type rf_mem [bmeu_pkg::REG_COUNT];
   bmeu_pkg::byte_type dm_mem [MEM_DEPTH];
   logic [bmeu_pkg::REG_COUNT-1:0] rf_vld_ff;
   logic [MEM_DEPTH-1:0]           dm_vld_ff;

   // Execute stage registers.
   logic               s1_valid_ff;
   logic [3:0]         s1_op_ff;
   logic [REG_AW-1:0]  s1_r_ff;
   logic [REG_AW-1:0]  s1_t_ff;
   logic [REG_AW-1:0]  s1_ra_ff;
   logic [REG_AW-1:0]  s1_rb_ff;
   logic [MEM_AW-1:0]  s1_maddr_ff;
   logic [7:0]         s1_addr_ff;
   logic [7:0]         s1_pc_ff;
   bmeu_pkg::byte_type rf_qa_ff;
   bmeu_pkg::byte_type rf_qb_ff;
   bmeu_pkg::byte_type dm_q_ff;
   logic               rf_va_ff;
   logic               rf_vb_ff;
   logic               dm_v_ff;

   // Forwarding registers: the write that took place at the same edge as the
   // read of the request now in the execute stage.
   logic               fwd_rf_we_ff;
   logic [REG_AW-1:0]  fwd_rf_addr_ff;
   bmeu_pkg::byte_type fwd_rf_data_ff;
   logic               fwd_dm_we_ff;
   logic [MEM_AW-1:0]  fwd_dm_addr_ff;
   bmeu_pkg::byte_type fwd_dm_data_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [7:0]         rsp_next_pc_ff;
   logic               rsp_jump_taken_ff;
   logic               rsp_halted_ff;
   bmeu_pkg::byte_type rsp_written_value_ff;

   logic               accept;
   logic               s1_fire;
   logic [REG_AW-1:0]  rd_addr_a;
   logic [REG_AW-1:0]  rd_addr_b;
   logic [MEM_AW-1:0]  rd_maddr;

   bmeu_pkg::byte_type opa;
   bmeu_pkg::byte_type opb;
   bmeu_pkg::byte_type opm;
   logic [15:0]        rot_word;

   logic               ex_rf_we;
   logic [REG_AW-1:0]  ex_rf_addr;
   logic               ex_dm_we;
   logic [7:0]         ex_next_pc;
   logic               ex_jump;
   logic               ex_halt;
   bmeu_pkg::byte_type ex_value;
   logic               wb_rf_we;
   logic               wb_dm_we;

   // Handshake. The execute stage moves on whenever the result register is
   // empty or being emptied, so a request is taken while a finished result
   // still waits at the output.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   // Read port selection. Port A carries S for the operations that read S,
   // and R otherwise; port B carries T, or register 0 for the jumps.
   always_comb begin
      case (req_operation) inside
         bmeu_pkg::OP_MOVE, bmeu_pkg::OP_ADD, bmeu_pkg::OP_FADD,
         bmeu_pkg::OP_OR, bmeu_pkg::OP_AND, bmeu_pkg::OP_XOR: begin
            rd_addr_a = req_reg_s;
         end
         default: begin
            rd_addr_a = req_reg_r;
         end
      endcase
      case (req_operation) inside
         bmeu_pkg::OP_JEQ, bmeu_pkg::OP_JGT: begin
            rd_addr_b = '0;
         end
         default: begin
            rd_addr_b = req_reg_t;
         end
      endcase
   end

   assign rd_maddr = wrap_tab[req_address_byte];

   // Register file and data memory: synchronous read on accept, write when
   // the request in the execute stage leaves it.
   always_ff @(posedge clock) begin
      if (wb_rf_we) begin
         rf_mem[ex_rf_addr] <= ex_value;
      end
      if (accept) begin
         rf_qa_ff <= rf_mem[rd_addr_a];
         rf_qb_ff <= rf_mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (wb_dm_we) begin
         dm_mem[s1_maddr_ff] <= ex_value;
      end
      if (accept) begin
         dm_q_ff <= dm_mem[rd_maddr];
      end
   end

   // Valid bits for both stores.
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
         dm_vld_ff <= '0;
      end else begin
         if (wb_rf_we) begin
            rf_vld_ff[ex_rf_addr] <= 1'b1;
         end
         if (wb_dm_we) begin
            dm_vld_ff[s1_maddr_ff] <= 1'b1;
         end
      end
   end

   // Execute stage control and payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_rf_we_ff <= 1'b0;
         fwd_dm_we_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            fwd_rf_we_ff <= wb_rf_we;
            fwd_dm_we_ff <= wb_dm_we;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= req_operation;
         s1_r_ff        <= req_reg_r;
         s1_t_ff        <= req_reg_t;
         s1_ra_ff       <= rd_addr_a;
         s1_rb_ff       <= rd_addr_b;
         s1_maddr_ff    <= rd_maddr;
         s1_addr_ff     <= req_address_byte;
         s1_pc_ff       <= req_current_pc;
         rf_va_ff       <= rf_vld_ff[rd_addr_a];
         rf_vb_ff       <= rf_vld_ff[rd_addr_b];
         dm_v_ff        <= dm_vld_ff[rd_maddr];
         fwd_rf_addr_ff <= ex_rf_addr;
         fwd_rf_data_ff <= ex_value;
         fwd_dm_addr_ff <= s1_maddr_ff;
         fwd_dm_data_ff <= ex_value;
      end
   end

   // Operands: the forwarded write wins over the stored data, and an entry
   // never written reads as zero.
   always_comb begin
      if (fwd_rf_we_ff && fwd_rf_addr_ff == s1_ra_ff) begin
         opa = fwd_rf_data_ff;
      end else begin
         opa = rf_va_ff ? rf_qa_ff : 8'h00;
      end
      if (fwd_rf_we_ff && fwd_rf_addr_ff == s1_rb_ff) begin
         opb = fwd_rf_data_ff;
      end else begin
         opb = rf_vb_ff ? rf_qb_ff : 8'h00;
      end
      if (fwd_dm_we_ff && fwd_dm_addr_ff == s1_maddr_ff) begin
         opm = fwd_dm_data_ff;
      end else begin
         opm = dm_v_ff ? dm_q_ff : 8'h00;
      end
   end

   assign rot_word = {opa, opa} >> s1_addr_ff[2:0];

   // Execute. Each operation gives the written byte, the next program counter
   // and the write enables of the two stores.
   always_comb begin
      ex_rf_we   = 1'b0;
      ex_rf_addr = s1_r_ff;
      ex_dm_we   = 1'b0;
      ex_next_pc = s1_pc_ff;
      ex_jump    = 1'b0;
      ex_halt    = 1'b0;
      ex_value   = 8'h00;
      unique case (s1_op_ff)
         bmeu_pkg::OP_LDMEM: begin
            ex_value = opm;
            ex_rf_we = 1'b1;
         end
         bmeu_pkg::OP_LDIMM: begin
            ex_value = s1_addr_ff;
            ex_rf_we = 1'b1;
         end
         bmeu_pkg::OP_STORE: begin
            ex_value = opa;
            ex_dm_we = 1'b1;
         end
         bmeu_pkg::OP_MOVE: begin
            ex_value   = opa;
            ex_rf_addr = s1_t_ff;
            ex_rf_we   = 1'b1;
         end
         bmeu_pkg::OP_ADD: begin
            ex_value = opa + opb;
            ex_rf_we = 1'b1;
         end
         bmeu_pkg::OP_FADD: begin
            ex_value = bmeu_pkg::float_add(opa, opb);
            ex_rf_we = 1'b1;
         end
         bmeu_pkg::OP_OR: begin
            ex_value = opa | opb;
            ex_rf_we = 1'b1;
         end
         bmeu_pkg::OP_AND: begin
            ex_value = opa & opb;
            ex_rf_we = 1'b1;
         end
         bmeu_pkg::OP_XOR: begin
            ex_value = opa ^ opb;
            ex_rf_we = 1'b1;
         end
         bmeu_pkg::OP_ROR: begin
            ex_value = rot_word[7:0];
            ex_rf_we = 1'b1;
         end
         bmeu_pkg::OP_JEQ: begin
            if (opa == opb) begin
               ex_jump    = 1'b1;
               ex_next_pc = s1_addr_ff;
            end
         end
         bmeu_pkg::OP_HALT: begin
            ex_halt = 1'b1;
         end
         bmeu_pkg::OP_JGT: begin
            if ($signed(opa) > $signed(opb)) begin
               ex_jump    = 1'b1;
               ex_next_pc = s1_addr_ff;
            end
         end
         default: begin
            // Unused operation codes change nothing.
         end
      endcase
   end

   assign wb_rf_we = s1_fire && ex_rf_we;
   assign wb_dm_we = s1_fire && ex_dm_we;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_next_pc_ff       <= ex_next_pc;
         rsp_jump_taken_ff    <= ex_jump;
         rsp_halted_ff        <= ex_halt;
         rsp_written_value_ff <= ex_value;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = rsp_next_pc_ff;
   assign rsp_jump_taken    = rsp_jump_taken_ff;
   assign rsp_halted        = rsp_halted_ff;
   assign rsp_written_value = rsp_written_value_ff;

endmodule

`default_nettype wire

// ===== design/bmeu_checker.sv =====
// Port-level checker for the byte machine execute unit, with the bind that
// attaches it to the top level. Depends on byte_machine_execute_unit's ports.
`default_nettype none

module bmeu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_next_pc,
   input wire logic       rsp_jump_taken,
   input wire logic       rsp_halted,
   input wire logic [7:0] rsp_written_value
);

   // Reset empties the result register.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result still valid after reset");

   // With no result waiting, the unit must be able to take a request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with the output empty");

   // A stalled result holds.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc) &&
      $stable(rsp_jump_taken) && $stable(rsp_halted) && $stable(rsp_written_value))
      else $error("stalled result changed");

   // Jumps and halt write nothing, and never occur together.
   a_jump_halt_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_jump_taken || rsp_halted) |->
      rsp_written_value == 8'h00 && !(rsp_jump_taken && rsp_halted))
      else $error("jump or halt with a written value");

endmodule

bind byte_machine_execute_unit bmeu_checker u_bmeu_checker (.*);

`default_nettype wire
